// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/mvmb_pkg.sv =====
// Package with item types, codes and fixed widths of the matrix-vector block.
`default_nettype none

package mvmb_pkg;

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = 48;
  localparam int FRAC_BITS = 12;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_ELEM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [5:0]               row_index;
    logic [9:0]               col_index;
    logic signed [DATA_W-1:0] value;
    logic                     last_element;
  } mvmb_in_t;

  typedef struct packed {
    logic [5:0]              out_row;
    logic signed [SUM_W-1:0] row_sum;
    logic                    last_row;
    logic                    length_error;
  } mvmb_out_t;

  // Control that travels with one memory read into the multiply-accumulate pipe.
  typedef struct packed {
    logic valid;
    logic first;
  } mvmb_mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mvmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mvmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mvmb_mac.sv =====
// Multiply-accumulate pipeline fed by the weight and vector memory read ports.
`default_nettype none

module mvmb_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  mvmb_pkg::mvmb_mac_ctrl_t      ctrl,
  input  logic signed [mvmb_pkg::DATA_W-1:0] w_data,
  input  logic signed [mvmb_pkg::DATA_W-1:0] v_data,
  output logic signed [mvmb_pkg::SUM_W-1:0]  acc,
  output logic                          busy
);

  import mvmb_pkg::*;

  mvmb_mac_ctrl_t           s1;
  mvmb_mac_ctrl_t           s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_ext;

  assign prod_ext = {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign busy     = s1.valid | s2.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= ctrl;
      s2 <= s1;
    end
  end

  // Stage one sees the memory data; stage two folds the product into the sum.
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      prod <= w_data * v_data;
    end
    if (s2.valid) begin
      acc <= s2.first ? prod_ext : acc + prod_ext;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_vector_multiply_bias_core.sv =====
// Top level of the matrix-vector multiply with per-row bias.
//
// Usage: input items on in_valid/in_ready/in_data load weights (opcode
// weight, by row and column), biases (opcode bias, by row) or vector
// elements (opcode element, by column). Loads are taken one per cycle
// while no run is in progress. The element item with last_element set
// closes the vector and starts a run; in_ready stays low until the run
// has placed its final result. A run reads one weight and one vector word
// per cycle from the memories while it works through a row, feeding the
// single multiply-accumulate unit and its memory-to-sum pipe.
// Results leave on out_valid/out_ready/out_data, one per row, last_row on
// the final one. A vector length that differs from the clamped cols_in_use
// gives a single result with length_error set instead. A stalled receiver
// holds the output register, and the run waits at the end of the next row
// until the register is free; loads keep flowing while a final result
// waits. Configuration is written through cfg_write, cfg_index and cfg_data;
// the user must write it only while idle, which the block itself does not enforce.
// Reset clears the element count, the registers to their defaults and the
// control state; memory contents are undefined until written.
`default_nettype none

module matrix_vector_multiply_bias_core #(
  parameter int ROWS_MAX = 64,
  parameter int COLS_MAX = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mvmb_pkg::mvmb_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mvmb_pkg::mvmb_out_t               out_data,
  input  logic                              cfg_write,
  input  logic [mvmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvmb_pkg::CFG_W-1:0]        cfg_data
);

  import mvmb_pkg::*;

  localparam int RW  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CW  = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int WD  = ROWS_MAX * COLS_MAX;
  localparam int RAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int CLW = ($clog2(COLS_MAX + 1) > CFG_W) ? $clog2(COLS_MAX + 1) : CFG_W;
  localparam int RCW = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [RCW-1:0]     rows_in_use;
  logic [CFG_W-1:0]   cols_in_use;
  logic               bias_enable;
  logic [COUNT_W-1:0] element_count;

  logic [RW-1:0] row_cnt, row_cnt_next;
  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;

  logic               in_accept;
  logic               elem_accept;
  logic               run_start;
  logic [COUNT_W-1:0] count_inc;
  logic [RCW-1:0]     rows_c;
  logic [CLW-1:0]     cols_c;
  logic               length_ok;
  logic               out_free;
  logic               out_load;
  mvmb_out_t          out_next;

  logic               w_we;
  logic [RAW-1:0]     w_waddr;
  logic [RAW-1:0]     w_raddr;
  logic [DATA_W-1:0]  w_rdata;
  logic               v_we;
  logic [DATA_W-1:0]  v_rdata;
  logic               b_we;
  logic [DATA_W-1:0]  b_rdata;

  mvmb_mac_ctrl_t           mac_ctrl;
  logic signed [SUM_W-1:0]  mac_acc;
  logic                     mac_busy;
  logic signed [SUM_W-1:0]  bias_term;
  logic signed [SUM_W-1:0]  row_total;

  assign in_ready    = (state == ST_IDLE);
  assign in_accept   = in_valid & in_ready;
  assign elem_accept = in_accept & (in_data.opcode == OP_ELEM);
  assign run_start   = elem_accept & in_data.last_element;
  assign count_inc   = (element_count == COUNT_MAX) ? element_count
                                                    : element_count + 1'b1;

  // Register values outside the legal range are clamped when a run starts.
  always_comb begin
    rows_c = rows_in_use;
    if (rows_in_use == '0) begin
      rows_c = RCW'(1);
    end else if (32'(rows_in_use) > ROWS_MAX) begin
      rows_c = RCW'(ROWS_MAX);
    end
    cols_c = CLW'(cols_in_use);
    if (cols_in_use == '0) begin
      cols_c = CLW'(1);
    end else if (32'(cols_in_use) > COLS_MAX) begin
      cols_c = CLW'(COLS_MAX);
    end
  end

  assign length_ok = (CLW'(count_inc) == cols_c);

  // Configuration registers and element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= RCW'(64);
      cols_in_use   <= CFG_W'(1024);
      bias_enable   <= 1'b1;
      element_count <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS:    rows_in_use <= cfg_data[RCW-1:0];
          REG_COLS:    cols_in_use <= cfg_data;
          REG_BIAS_EN: bias_enable <= cfg_data[0];
          default:     ;
        endcase
      end
      if (run_start) begin
        element_count <= '0;
      end else if (elem_accept) begin
        element_count <= count_inc;
      end
    end
  end

  // Memory write and read ports.
  assign w_we    = in_accept & (in_data.opcode == OP_WEIGHT)
                 & (32'(in_data.row_index) < ROWS_MAX)
                 & (32'(in_data.col_index) < COLS_MAX);
  assign w_waddr = RAW'(32'(in_data.row_index) * COLS_MAX + 32'(in_data.col_index));
  assign w_raddr = RAW'(32'(row_cnt) * COLS_MAX + 32'(col_cnt));
  assign v_we    = elem_accept & (32'(in_data.col_index) < COLS_MAX);
  assign b_we    = in_accept & (in_data.opcode == OP_BIAS)
                 & (32'(in_data.row_index) < ROWS_MAX);

  mvmb_ram #(.WIDTH(DATA_W), .DEPTH(WD)) u_weight_mem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_data.value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mvmb_ram #(.WIDTH(DATA_W), .DEPTH(COLS_MAX)) u_vector_mem (
    .clk   (clk),
    .we    (v_we),
    .waddr (CW'(in_data.col_index)),
    .wdata (in_data.value),
    .raddr (col_cnt),
    .rdata (v_rdata)
  );

  // The bias read address is the current row, so its data settles early in the row.
  mvmb_ram #(.WIDTH(DATA_W), .DEPTH(ROWS_MAX)) u_bias_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (RW'(in_data.row_index)),
    .wdata (in_data.value),
    .raddr (row_cnt),
    .rdata (b_rdata)
  );

  assign mac_ctrl.valid = (state == ST_CALC);
  assign mac_ctrl.first = (col_cnt == '0);

  mvmb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .w_data (w_rdata),
    .v_data (v_rdata),
    .acc    (mac_acc),
    .busy   (mac_busy)
  );

  assign bias_term = bias_enable
                   ? {{(SUM_W - DATA_W - FRAC_BITS){b_rdata[DATA_W-1]}}, b_rdata,
                      {FRAC_BITS{1'b0}}}
                   : '0;
  assign row_total = mac_acc + bias_term;
  assign out_free  = ~out_valid | out_ready;

  // Run sequencer.
  always_comb begin
    state_next   = state;
    row_cnt_next = row_cnt;
    col_cnt_next = col_cnt;
    out_load     = 1'b0;
    out_next     = '0;
    case (state)
      ST_IDLE: begin
        if (run_start) begin
          row_cnt_next = '0;
          col_cnt_next = '0;
          state_next   = length_ok ? ST_CALC : ST_ERR;
        end
      end
      ST_CALC: begin
        if (col_cnt == col_last) begin
          state_next = ST_DRAIN;
        end else begin
          col_cnt_next = col_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && out_free) begin
          out_load          = 1'b1;
          out_next.out_row  = 6'(row_cnt);
          out_next.row_sum  = row_total;
          out_next.last_row = (row_cnt == row_last);
          if (row_cnt == row_last) begin
            state_next = ST_IDLE;
          end else begin
            row_cnt_next = row_cnt + 1'b1;
            col_cnt_next = '0;
            state_next   = ST_CALC;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_next.last_row     = 1'b1;
          out_next.length_error = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_cnt   <= '0;
      col_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      row_last <= RW'(rows_c - 1'b1);
      col_last <= CW'(cols_c - 1'b1);
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mvmb_checker.sv =====
// Port-level checker for the matrix-vector block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mvmb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input mvmb_pkg::mvmb_in_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input mvmb_pkg::mvmb_out_t            out_data
);

  import mvmb_pkg::*;

  logic run_start;

  assign run_start = in_valid & in_ready & (in_data.opcode == OP_ELEM)
                   & in_data.last_element;

  // A waiting result must hold until it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // An error result is a single item with zero row and sum that closes the run.
  `ASSERT_IMPL(a_err_shape, out_valid && out_data.length_error, out_data.last_row && out_data.out_row == '0 && out_data.row_sum == '0)
  // Once a run starts, in_ready goes low.
  `ASSERT_NEXT(a_run_blocks, run_start, !in_ready)
  // Nothing is offered right after reset.
  `ASSERT_IMPL(a_reset_quiet, $past(rst), !out_valid)

endmodule

bind matrix_vector_multiply_bias_core mvmb_checker u_mvmb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the matrix-vector multiply with per-row bias.
`timescale 1ns / 1ps

module testbench;
  import mvmb_pkg::*;

  localparam int ROWS_MAX       = 64;
  localparam int COLS_MAX       = 1024;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASE_ITEMS    = 16;

  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam mvmb_out_t LENGTH_ERR = '{out_row: '0, row_sum: '0, last_row: 1'b1,
                                       length_error: 1'b1};

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
    mvmb_in_t             item;
    bit                   typed;
    mvmb_out_t            want;
  } step_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  mvmb_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mvmb_out_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Shadow copy of the block's memories, element count and registers.
  logic signed [DATA_W-1:0] weight_img [0:ROWS_MAX*COLS_MAX-1];
  logic signed [DATA_W-1:0] bias_img   [0:ROWS_MAX-1];
  logic signed [DATA_W-1:0] vector_img [0:COLS_MAX-1];
  logic [COUNT_W-1:0]       elem_count = '0;
  logic [6:0]               rows_cfg   = 7'd64;
  logic [10:0]              cols_cfg   = 11'd1024;
  logic                     bias_cfg   = 1'b1;

  mvmb_out_t run_sums[$];
  mvmb_out_t pending_sums[$];
  step_t     directed_steps[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;

  matrix_vector_multiply_bias_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic mvmb_in_t make_item(logic [1:0] op, int row, int col,
                                         logic [DATA_W-1:0] val, bit last);
    mvmb_in_t it;
    it.opcode       = op;
    it.row_index    = row[5:0];
    it.col_index    = col[9:0];
    it.value        = val;
    it.last_element = last;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'h8000;
    if (roll == 1) return 16'h7FFF;
    return DATA_W'($urandom());
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int active_cols();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > COLS_MAX) return COLS_MAX;
    return int'(cols_cfg);
  endfunction

  function automatic void add_item(mvmb_in_t it, bit typed = 1'b0, mvmb_out_t want = '0);
    step_t s;
    s = '{is_reg: 1'b0, reg_idx: '0, reg_data: '0, item: it, typed: typed, want: want};
    directed_steps.push_back(s);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int data);
    step_t s;
    s = '{is_reg: 1'b1, reg_idx: idx, reg_data: data[CFG_W-1:0], item: '0, typed: 1'b0,
          want: '0};
    directed_steps.push_back(s);
  endfunction

  // Updates the shadow state with one accepted item and leaves any expected results in run_sums.
  task automatic compute_row_sums(input mvmb_in_t it);
    int nrows, ncols, r, c;
    logic signed [SUM_W-1:0] acc;
    mvmb_out_t res;
    run_sums.delete();
    // Row and column fields cannot exceed the memory sizes, so every load lands.
    case (it.opcode)
      OP_WEIGHT: weight_img[{it.row_index, it.col_index}] = it.value;
      OP_BIAS:   bias_img[it.row_index] = it.value;
      OP_ELEM: begin
        vector_img[it.col_index] = it.value;
        if (elem_count != COUNT_MAX) elem_count = elem_count + 1'b1;
        if (it.last_element) begin
          nrows = (rows_cfg == 0) ? 1 : ((rows_cfg > ROWS_MAX) ? ROWS_MAX : int'(rows_cfg));
          ncols = active_cols();
          if (elem_count != ncols) begin
            run_sums.push_back(LENGTH_ERR);
          end else begin
            for (r = 0; r < nrows; r++) begin
              acc = '0;
              for (c = 0; c < ncols; c++) begin
                acc = acc + weight_img[r * COLS_MAX + c] * vector_img[c];
              end
              // The bias is a Q4.12 word lined up with the Q24.24 sum.
              if (bias_cfg) acc = acc + $signed({bias_img[r], 12'b0});
              res.out_row      = 6'(r);
              res.row_sum      = acc;
              res.last_row     = (r == nrows - 1);
              res.length_error = 1'b0;
              run_sums.push_back(res);
            end
          end
          elem_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input mvmb_in_t it, input bit typed = 1'b0,
                           input mvmb_out_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_row_sums(it);
    if (typed) begin
      pending_sums.push_back(want);
    end else begin
      foreach (run_sums[i]) pending_sums.push_back(run_sums[i]);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ROWS:    rows_cfg = data[6:0];
      REG_COLS:    cols_cfg = data[10:0];
      REG_BIAS_EN: bias_cfg = data[0];
      default: ;
    endcase
  endtask

  // Mostly elements that complete a vector of the right length, with loads,
  // unused opcodes and early last marks mixed in.
  function automatic mvmb_in_t random_item();
    int roll;
    int count;
    bit closes;
    roll   = $urandom_range(0, 99);
    count  = int'(elem_count);
    closes = (count + 1 >= active_cols());
    if (roll < 10)
      return make_item(OP_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 1023), rand_value(),
                       $urandom_range(0, 1));
    if (roll < 15)
      return make_item(OP_BIAS, $urandom_range(0, 63), $urandom_range(0, 1023), rand_value(),
                       $urandom_range(0, 1));
    if (roll < 20)
      return make_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 1023), rand_value(),
                       $urandom_range(0, 1));
    if (roll < 25)
      return make_item(OP_ELEM, 0, $urandom_range(0, 1023), rand_value(), 1'b1);
    return make_item(OP_ELEM, 0,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : count % COLS_MAX,
                     rand_value(), closes);
  endfunction

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : row_sum_check
    mvmb_out_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end else if (out_valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, out_row %0d row_sum %0h",
                   $time, out_data.out_row, out_data.row_sum);
        end else begin
          want = pending_sums.pop_front();
          if (out_data.out_row !== want.out_row) begin
            mismatches++;
            $display("%0t ns: out_row expected %0d got %0d", $time, want.out_row,
                     out_data.out_row);
          end
          if (out_data.row_sum !== want.row_sum) begin
            mismatches++;
            $display("%0t ns: row_sum expected %0h got %0h", $time, want.row_sum,
                     out_data.row_sum);
          end
          if (out_data.last_row !== want.last_row) begin
            mismatches++;
            $display("%0t ns: last_row expected %0b got %0b", $time, want.last_row,
                     out_data.last_row);
          end
          if (out_data.length_error !== want.length_error) begin
            mismatches++;
            $display("%0t ns: length_error expected %0b got %0b", $time, want.length_error,
                     out_data.length_error);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    int counted;
    mvmb_in_t it;

    // Right after reset the vector length is 1024, so a lone last element is an error.
    add_item(make_item(OP_ELEM, 0, 5, 16'h1234, 1'b1), 1'b1, LENGTH_ERR);
    add_item(make_item(OP_UNUSED, 63, 1023, 16'hFFFF, 1'b1));
    add_item(make_item(OP_WEIGHT, 63, 1023, 16'h7FFF, 1'b1));
    add_item(make_item(OP_BIAS, 0, 0, 16'h8000, 1'b1));
    // Zero in both size registers is taken as one row and one column.
    add_reg(REG_ROWS, 0);
    add_reg(REG_COLS, 0);
    add_reg(REG_BIAS_EN, 0);
    add_item(make_item(OP_WEIGHT, 0, 0, 16'h8000, 1'b0));
    add_item(make_item(OP_ELEM, 0, 0, 16'h8000, 1'b1), 1'b1,
             '{out_row: '0, row_sum: 48'sh0000_4000_0000, last_row: 1'b1, length_error: 1'b0});
    add_item(make_item(OP_WEIGHT, 0, 0, 16'h7FFF, 1'b0));
    add_item(make_item(OP_ELEM, 0, 0, 16'h7FFF, 1'b1), 1'b1,
             '{out_row: '0, row_sum: 48'sh0000_3FFF_0001, last_row: 1'b1, length_error: 1'b0});
    add_item(make_item(OP_ELEM, 0, 0, 16'h8000, 1'b1));
    add_reg(REG_BIAS_EN, 1);
    add_item(make_item(OP_ELEM, 0, 0, 16'h0000, 1'b1));
    add_item(make_item(OP_BIAS, 0, 0, 16'h7FFF, 1'b0));
    add_item(make_item(OP_ELEM, 0, 0, 16'h8000, 1'b1));
    add_item(make_item(OP_ELEM, 0, 0, 16'h0001, 1'b0));
    add_item(make_item(OP_ELEM, 0, 0, 16'h0001, 1'b1), 1'b1, LENGTH_ERR);
    // The count starts over after an error, so one element is a full vector again.
    add_item(make_item(OP_ELEM, 0, 0, 16'h0C00, 1'b1));
    // A column count above the maximum is taken as 1024, so a short vector is an error.
    add_reg(REG_COLS, 2047);
    add_item(make_item(OP_ELEM, 0, 1, 16'h0400, 1'b1), 1'b1, LENGTH_ERR);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_reg)
        write_reg(directed_steps[k].reg_idx, int'(directed_steps[k].reg_data));
      else
        send_item(directed_steps[k].item, directed_steps[k].typed, directed_steps[k].want);
    end

    // Load column 0 of every row, then columns 1 to 3 and the biases of rows 0 to 7.
    no_idle = 1'b1;
    for (i = 0; i < ROWS_MAX; i++)
      send_item(make_item(OP_WEIGHT, i, 0, rand_value(), 1'b0));
    for (i = 0; i < 8 * 3; i++)
      send_item(make_item(OP_WEIGHT, i / 3, i % 3 + 1, rand_value(), 1'b0));
    for (i = 0; i < 8; i++)
      send_item(make_item(OP_BIAS, i, 0, rand_value(), 1'b0));

    // Fill the first four vector entries with a one-row run.
    write_reg(REG_ROWS, 1);
    write_reg(REG_COLS, 4);
    for (i = 0; i < 4; i++)
      send_item(make_item(OP_ELEM, 0, i, rand_value(), i == 3));

    // All rows on one column, with the receiver held off so the run backs up into the input.
    no_idle = 1'b0;
    write_reg(REG_ROWS, 127);
    write_reg(REG_COLS, 1);
    write_reg(REG_BIAS_EN, 0);
    hold_request = 1'b1;
    send_item(make_item(OP_ELEM, 0, 0, rand_value(), 1'b1));
    for (i = 0; i < 10; i++)
      send_item(make_item(OP_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 3),
                          rand_value(), 1'b0));

    for (phase = 0; phase < 6; phase++) begin
      no_idle = (phase == 3);
      i = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      write_reg(REG_ROWS, ($urandom_range(0, 15) << 7) | i);
      write_reg(REG_COLS, $urandom_range(0, 4));
      write_reg(REG_BIAS_EN, ($urandom_range(0, 1023) << 1) | $urandom_range(0, 1));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_item(it);
        if (it.opcode != OP_UNUSED) counted++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
